// ===== sv/ipr_pkg.sv =====
// ============================================================================
// Isolated pixel removal package
// Sizes, register indexes and shared types of the isolated pixel removal
// filter.
// ============================================================================
package ipr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int DIM_W     = 11;
    localparam int THR_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 4;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

    localparam int MIN_DIM = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_NEIGHBORS = CFG_IDX_W'(2);

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = DIM_W'(640);
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = DIM_W'(480);
    localparam logic [THR_W-1:0] RST_MIN_NEIGHBORS = THR_W'(1);

    // One window column: element 0 is the top row, element 2 the bottom row.
    typedef logic [2:0][PIX_W-1:0] ipr_col_t;

endpackage

// ===== sv/ipr_if.sv =====
// ============================================================================
// Isolated pixel removal channels
// Valid/ready channels for pixels, filtered results and register writes.
// ============================================================================
interface ipr_pix_if;
    import ipr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             fill;

    modport source (output valid, output pixel, output fill, input ready);
    modport sink (input valid, input pixel, input fill, output ready);
endinterface

interface ipr_res_if;
    import ipr_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             out_last;

    modport source (output valid, output out_pixel, output out_last, input ready);
    modport sink (input valid, input out_pixel, input out_last, output ready);
endinterface

interface ipr_cfg_if;
    import ipr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/ipr_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module ipr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ipr_cell.sv =====
// ============================================================================
// Window cell
// Holds one three-pixel column of the 3x3 window and passes it on to the
// next cell on every shift.
// ============================================================================
module ipr_cell
    import ipr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     shift_en,
    input  ipr_col_t col_in,
    output ipr_col_t col_out,
    output logic [2:0] nonzero
);

    ipr_col_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nonzero[i] = (col_reg[i] != '0);
        end
    end

endmodule

// ===== sv/isolated_pixel_removal.sv =====
// A result passes stage 1, stage 2 and the output register after the transfer
// of the item that completes its neighborhood (image_width+1 items later).
// Throughput: one item per cycle unless stalled, set by the single line store port pair.
// Reset: control, position counters and window clear at once and the
// registers return to 640 x 480 with a threshold of one; line stores are
// not cleared.
// ============================================================================
// Isolated pixel removal
// Line-buffered 3x3 filter that clears nonzero interior pixels with too few
// nonzero neighbors.
// ============================================================================
module isolated_pixel_removal
    import ipr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ipr_pix_if.sink   pixels,
    ipr_res_if.source filtered,
    ipr_cfg_if.sink   cfg
);

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [THR_W-1:0]  min_nbr_reg;
    logic              wr_width;
    logic              wr_height;
    logic              wr_thr;
    logic              cfg_acc;
    logic              cfg_hit;

    logic [WDIM_W-1:0] w_eff;
    logic [HDIM_W-1:0] h_eff;

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [HDIM_W-1:0] out_row_reg, out_row_next;
    logic              primed_reg, primed_next;

    logic              in_acc;
    logic              flushing;
    logic [PIX_W-1:0]  pix_val;
    logic              col_last;
    logic              out_col_last;
    logic              start_out;
    logic              frame_end;
    logic              emit;
    logic              out_interior;
    logic              out_is_last;

    logic              out_en;
    logic              s2_en;
    logic              s1_en;
    logic              s1_move;

    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_interior_reg;
    logic              s1_last_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [COL_W-1:0]  s1_col_reg;

    logic              s2_valid_reg;
    logic              s2_emit_reg;
    logic              s2_interior_reg;
    logic              s2_last_reg;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              out_last_reg;

    logic                 ram_we;
    logic                 ram_re;
    logic [COL_W-1:0]     ram_waddr;
    logic [COL_W-1:0]     ram_raddr;
    logic [2*PIX_W-1:0]   ram_wdata;
    logic [2*PIX_W-1:0]   ram_rdata;

    ipr_col_t          col_chain [4];
    logic [2:0]        nz [3];
    logic [7:0]        nbr_mask;
    logic [CNT_W-1:0]  nbr_count;
    logic [PIX_W-1:0]  centre;
    logic [PIX_W-1:0]  result;

    // Configuration registers.
    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid && cfg.ready;

    always_comb
    begin
        wr_width  = 1'b0;
        wr_height = 1'b0;
        wr_thr    = 1'b0;
        unique case (cfg.index)
            REG_IMAGE_WIDTH:   wr_width  = cfg_acc;
            REG_IMAGE_HEIGHT:  wr_height = cfg_acc;
            REG_MIN_NEIGHBORS: wr_thr    = cfg_acc;
            default:
            begin
                wr_width  = 1'b0;
                wr_height = 1'b0;
                wr_thr    = 1'b0;
            end
        endcase
    end

    assign cfg_hit = wr_width || wr_height || wr_thr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= RST_IMAGE_WIDTH;
            height_reg  <= RST_IMAGE_HEIGHT;
            min_nbr_reg <= RST_MIN_NEIGHBORS;
        end
        else
        begin
            if (wr_width)
            begin
                width_reg <= cfg.data;
            end
            if (wr_height)
            begin
                height_reg <= cfg.data;
            end
            if (wr_thr)
            begin
                min_nbr_reg <= cfg.data[THR_W-1:0];
            end
        end
    end

    // Frame geometry saturated to the supported range.
    always_comb
    begin
        if (32'(width_reg) < 32'(MIN_DIM))
        begin
            w_eff = WDIM_W'(MIN_DIM);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WDIM_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WDIM_W'(width_reg);
        end

        if (32'(height_reg) < 32'(MIN_DIM))
        begin
            h_eff = HDIM_W'(MIN_DIM);
        end
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
        begin
            h_eff = HDIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = HDIM_W'(height_reg);
        end
    end

    // Pipeline enables.
    assign out_en       = !out_valid_reg || filtered.ready;
    assign s2_en        = !s2_valid_reg || out_en;
    assign s1_en        = !s1_valid_reg || s2_en;
    assign s1_move      = s1_valid_reg && s2_en;
    assign pixels.ready = s1_en;
    assign in_acc       = pixels.valid && pixels.ready;

    // Stream position of the incoming item and of the next result.
    assign flushing     = in_row_reg >= ROW_W'(h_eff);
    assign pix_val      = (pixels.fill || flushing) ? '0 : pixels.pixel;
    assign col_last     = (WDIM_W'(in_col_reg) == w_eff - WDIM_W'(1));
    assign out_col_last = (WDIM_W'(out_col_reg) == w_eff - WDIM_W'(1));
    assign start_out    = (in_row_reg == ROW_W'(1)) && (in_col_reg == COL_W'(1));
    assign frame_end    = (in_row_reg == ROW_W'(h_eff) + ROW_W'(1)) && (in_col_reg == '0);
    assign emit         = primed_reg || start_out;
    assign out_interior = (out_row_reg != '0) && (out_row_reg < h_eff - HDIM_W'(1))
                          && (out_col_reg != '0)
                          && (WDIM_W'(out_col_reg) < w_eff - WDIM_W'(1));
    assign out_is_last  = (out_row_reg == h_eff - HDIM_W'(1)) && out_col_last;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        primed_next  = primed_reg;
        if (cfg_hit || (in_acc && frame_end))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            primed_next  = 1'b0;
        end
        else if (in_acc)
        begin
            primed_next = emit;
            if (col_last)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit)
            begin
                if (out_col_last)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + HDIM_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            out_col_reg     <= '0;
            out_row_reg     <= '0;
            primed_reg      <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s1_emit_reg     <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s2_emit_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            primed_reg  <= primed_next;
            if (s1_en)
            begin
                s1_valid_reg <= in_acc;
                s1_emit_reg  <= in_acc && emit;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
                s2_emit_reg  <= s1_valid_reg && s1_emit_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s2_valid_reg && s2_emit_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg      <= pix_val;
            s1_col_reg      <= in_col_reg;
            s1_interior_reg <= out_interior;
            s1_last_reg     <= out_is_last;
        end
        if (s1_move)
        begin
            s2_interior_reg <= s1_interior_reg;
            s2_last_reg     <= s1_last_reg;
        end
        if (out_en)
        begin
            out_pixel_reg <= result;
            out_last_reg  <= s2_last_reg;
        end
    end

    // Both line stores share one memory: upper row in the high byte.
    assign ram_re    = in_acc;
    assign ram_raddr = in_col_reg;
    assign ram_we    = s1_move;
    assign ram_waddr = s1_col_reg;
    assign ram_wdata = {ram_rdata[PIX_W-1:0], s1_pix_reg};

    ipr_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Window: the newest column enters the right cell and moves left.
    always_comb
    begin
        col_chain[3][0] = ram_rdata[2*PIX_W-1:PIX_W];
        col_chain[3][1] = ram_rdata[PIX_W-1:0];
        col_chain[3][2] = s1_pix_reg;
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_cell
        ipr_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (s1_move),
            .col_in   (col_chain[k + 1]),
            .col_out  (col_chain[k]),
            .nonzero  (nz[k])
        );
    end

    assign nbr_mask  = {nz[0], nz[2], nz[1][0], nz[1][2]};
    assign nbr_count = CNT_W'($countones(nbr_mask));
    assign centre    = col_chain[1][1];

    always_comb
    begin
        result = centre;
        if (s2_interior_reg && (centre != '0) && (nbr_count < min_nbr_reg))
        begin
            result = '0;
        end
    end

    assign filtered.valid     = out_valid_reg;
    assign filtered.out_pixel = out_pixel_reg;
    assign filtered.out_last  = out_last_reg;

`ifndef NO_ASSERTIONS
    // The line store reads the column it is writing back only when a new frame
    // starts over at column zero.
    a_ram_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re && (ram_waddr == ram_raddr) |-> ram_raddr == '0)
        else $error("line store read and write hit the same column");

    // Result production stops only at the end of a frame or on a register write.
    a_primed_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(primed_reg) |-> $past(cfg_hit || (in_acc && frame_end)))
        else $error("primed cleared outside a frame end");

    // The last pixel of a frame lies on the border and always yields a result.
    a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_last_reg |-> s2_emit_reg && !s2_interior_reg)
        else $error("frame end flag on an interior or silent item");

    // The input column stays inside the configured row.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        WDIM_W'(in_col_reg) < w_eff)
        else $error("input column beyond image width");
`endif

endmodule

// ===== test/ipr_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Isolated pixel removal checker
// Watches the pixel, result and register channels of the filter. It keeps
// its own line stores, 3x3 window and frame counters, works out the filtered
// pixel that each pixel transfer releases, and compares every result transfer
// with the oldest one still awaited.
// ============================================================================
module ipr_checker
    import ipr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ipr_pix_if   pixels,
    ipr_res_if   filtered,
    ipr_cfg_if   cfg,
    output int   failures,
    output int   pending,
    output int   results_seen
);

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
    } filtered_px_t;

    filtered_px_t awaited_px[$];
    filtered_px_t want;

    logic [PIX_W-1:0] upper_line [MAX_WIDTH];
    logic [PIX_W-1:0] middle_line [MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];

    int unsigned col_in;
    int unsigned row_in;
    int unsigned col_out;
    int unsigned row_out;
    bit          primed;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [THR_W-1:0] thr_reg;

    int idx;

    function automatic int unsigned dim_limit(logic [DIM_W-1:0] v, int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    function automatic void note_mismatch(string msg);
        failures++;
        if (failures <= 10)
            $display("Mismatch at %0t ns: %s", $time, msg);
    endfunction

    task automatic restart_frame();
        col_in  = 0;
        row_in  = 0;
        col_out = 0;
        row_out = 0;
        primed  = 0;
    endtask

    task automatic filter_pixel(input logic [PIX_W-1:0] raw, input logic is_fill);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      neighbors;
        int               r;
        int               k;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] centre;
        bit               frame_end;
        bit               interior;
        filtered_px_t     res;

        w  = dim_limit(width_reg, MAX_WIDTH);
        h  = dim_limit(height_reg, MAX_HEIGHT);
        px = (is_fill || row_in >= h) ? '0 : raw;
        c  = (col_in < MAX_WIDTH) ? col_in : 0;

        above = upper_line[c];
        mid   = middle_line[c];
        upper_line[c]  = mid;
        middle_line[c] = px;
        for (r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = above;
        win[1][2] = mid;
        win[2][2] = px;

        if (row_in == 1 && col_in == 1)
            primed = 1;
        frame_end = (row_in == h + 1 && col_in == 0);

        col_in++;
        if (col_in >= w)
        begin
            col_in = 0;
            row_in++;
        end

        if (primed)
        begin
            centre   = win[1][1];
            interior = row_out >= 1 && row_out + 2 <= h && col_out >= 1 && col_out + 2 <= w;
            if (interior && centre != 0)
            begin
                neighbors = 0;
                for (k = 0; k < 9; k++)
                    if (k != 4 && win[k / 3][k % 3] != 0)
                        neighbors++;
                if (neighbors < thr_reg)
                    centre = '0;
            end
            res.value = centre;
            res.last  = (row_out == h - 1 && col_out == w - 1);
            awaited_px.insert(awaited_px.size(), res);
            col_out++;
            if (col_out >= w)
            begin
                col_out = 0;
                row_out++;
            end
        end

        if (frame_end)
            restart_frame();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_px.delete();
            for (idx = 0; idx < MAX_WIDTH; idx++)
            begin
                upper_line[idx]  = '0;
                middle_line[idx] = '0;
            end
            for (idx = 0; idx < 9; idx++)
                win[idx / 3][idx % 3] = '0;
            restart_frame();
            width_reg    = RST_IMAGE_WIDTH;
            height_reg   = RST_IMAGE_HEIGHT;
            thr_reg      = RST_MIN_NEIGHBORS;
            failures     = 0;
            results_seen = 0;
            pending     <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg = cfg.data;
                        restart_frame();
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg = cfg.data;
                        restart_frame();
                    end
                    REG_MIN_NEIGHBORS:
                    begin
                        thr_reg = cfg.data[THR_W-1:0];
                        restart_frame();
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (filtered.valid && filtered.ready)
            begin
                results_seen++;
                if (awaited_px.size() == 0)
                    note_mismatch($sformatf("result %0d (pixel %0d, last %0b) with nothing awaited",
                                            results_seen, filtered.out_pixel, filtered.out_last));
                else
                begin
                    want = awaited_px.pop_front();
                    if (filtered.out_pixel !== want.value)
                        note_mismatch($sformatf("result %0d pixel: expected %0d, got %0d",
                                                results_seen, want.value, filtered.out_pixel));
                    if (filtered.out_last !== want.last)
                        note_mismatch($sformatf("result %0d last flag: expected %0b, got %0b",
                                                results_seen, want.last, filtered.out_last));
                end
            end

            if (pixels.valid && pixels.ready)
                filter_pixel(pixels.pixel, pixels.fill);

            pending <= awaited_px.size();
        end
    end

endmodule

// ===== test/tb_isolated_pixel_removal.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Isolated pixel removal testbench
// Streams frames into the filter: a hand-made frame, a sweep of geometries
// and thresholds including sizes below the minimum, then random frames with
// noise, cut-off frames and spare register writes. Both ends of the stream
// stall at random; the checker judges every result.
// ============================================================================
module tb_isolated_pixel_removal;
    import ipr_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 360;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    logic clk = 1'b0;
    logic rst_n;

    ipr_pix_if pixels ();
    ipr_res_if filtered ();
    ipr_cfg_if cfg ();

    int failures;
    int pending;
    int results_seen;

    bit lazy;
    bit hold_go;
    int quiet;
    int items_sent;
    int frames_done;
    int cfg_writes;

    logic [DIM_W-1:0] cur_w;
    logic [DIM_W-1:0] cur_h;
    logic [DIM_W-1:0] thr_data;

    isolated_pixel_removal uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixels   (pixels),
        .filtered (filtered),
        .cfg      (cfg)
    );

    ipr_checker filter_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixels       (pixels),
        .filtered     (filtered),
        .cfg          (cfg),
        .failures     (failures),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver either stalls at random or, on request, holds off for a
    // long stretch so that the filter fills up and refuses new pixels.
    initial
    begin
        filtered.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                filtered.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_go <= 1'b0;
            end
            else
                filtered.ready <= !(lazy && $urandom_range(0, 99) < 19);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixels.valid && pixels.ready) || (filtered.valid && filtered.ready) ||
            (cfg.valid && cfg.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("No transfer for %0d cycles, giving up.", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned dim_limit(logic [DIM_W-1:0] v, int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    task automatic send_item(input logic [PIX_W-1:0] value, input logic is_fill);
        while (lazy && $urandom_range(0, 99) < 19)
        begin
            pixels.valid <= 1'b0;
            @(posedge clk);
        end
        pixels.valid <= 1'b1;
        pixels.pixel <= value;
        pixels.fill  <= is_fill;
        do
            @(posedge clk);
        while (!pixels.ready);
        items_sent++;
    endtask

    task automatic drain_results();
        pixels.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= index;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    // A frame is width*height pixels followed by width+1 flush items. A cut
    // either abandons the frame with a register write that restarts the filter's
    // frame, or pauses it for a write to the unused index and then carries on.
    task automatic send_frame(input int density, input bit noisy, input int cut_at,
                              input bit spare_cut);
        int unsigned      w;
        int unsigned      h;
        int               n;
        int               total;
        logic [PIX_W-1:0] value;
        logic             is_fill;

        w     = dim_limit(cur_w, MAX_WIDTH);
        h     = dim_limit(cur_h, MAX_HEIGHT);
        total = w * (h + 1) + 1;
        for (n = 0; n < total; n++)
        begin
            if (n == cut_at)
            begin
                drain_results();
                if (spare_cut)
                    write_reg(REG_SPARE, DIM_W'($urandom));
                else
                begin
                    write_reg(REG_MIN_NEIGHBORS, thr_data);
                    return;
                end
            end
            if (n < w * h)
            begin
                is_fill = noisy && $urandom_range(0, 99) < 3;
                if (is_fill || $urandom_range(0, 99) < density)
                    value = PIX_W'($urandom_range(1, 255));
                else
                    value = '0;
            end
            else
            begin
                is_fill = !(noisy && $urandom_range(0, 99) < 30);
                value   = PIX_W'($urandom);
            end
            send_item(value, is_fill);
        end
        frames_done++;
    endtask

    task automatic run_setting(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input logic [DIM_W-1:0] thr, input int density);
        drain_results();
        cur_w    = w;
        cur_h    = h;
        thr_data = thr;
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_MIN_NEIGHBORS, thr);
        send_frame(density, 1'b0, -1, 1'b0);
    endtask

    initial
    begin
        logic [PIX_W-1:0] demo_px [20];
        int               n;
        int               frame_no;
        int               start_items;
        int               roll;
        int               cut_at;
        bit               spare_cut;
        int unsigned      total;
        logic [THR_W-1:0] thr;

        demo_px = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd6,
                    8'd0, 8'd9, 8'd0, 8'd0, 8'd0,
                    8'd0, 8'd0, 8'd0, 8'd77, 8'd0,
                    8'd128, 8'd0, 8'd0, 8'd0, 8'd0};

        rst_n         = 1'b0;
        pixels.valid <= 1'b0;
        pixels.pixel <= '0;
        pixels.fill  <= 1'b0;
        cfg.valid    <= 1'b0;
        cfg.index    <= '0;
        cfg.data     <= '0;
        lazy          = 1'b1;
        hold_go       = 1'b0;
        items_sent    = 0;
        frames_done   = 0;
        cfg_writes    = 0;
        cur_w         = RST_IMAGE_WIDTH;
        cur_h         = RST_IMAGE_HEIGHT;
        thr_data      = DIM_W'(RST_MIN_NEIGHBORS);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // A 5x4 frame under the reset threshold: a kept pixel, an isolated
        // pixel, nonzero borders, a fill among the pixels and a pixel among
        // the flush items.
        cur_w = 11'd5;
        cur_h = 11'd4;
        write_reg(REG_IMAGE_WIDTH, cur_w);
        write_reg(REG_IMAGE_HEIGHT, cur_h);
        for (n = 0; n < 26; n++)
        begin
            if (n == 7)
                send_item(8'hAA, 1'b1);
            else if (n < 20)
                send_item(demo_px[n], 1'b0);
            else if (n == 22)
                send_item(8'hFF, 1'b0);
            else
                send_item(8'h55, 1'b1);
        end
        frames_done++;

        run_setting(11'd6, 11'd5, 11'h7F0, 85);
        run_setting(11'd6, 11'd5, 11'h009, 85);
        run_setting(11'd6, 11'd5, 11'h008, 95);

        lazy = 1'b0;
        run_setting(11'd7, 11'd4, 11'h00F, 70);
        run_setting(11'd0, 11'd2, 11'h001, 60);
        lazy = 1'b1;

        frame_no    = 0;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            if (frame_no == 0 || $urandom_range(0, 99) < 55)
            begin
                drain_results();
                if ($urandom_range(0, 99) < 70)
                begin
                    cur_w = DIM_W'($urandom_range(0, 14));
                    write_reg(REG_IMAGE_WIDTH, cur_w);
                end
                if ($urandom_range(0, 99) < 70)
                begin
                    cur_h = DIM_W'($urandom_range(0, 10));
                    write_reg(REG_IMAGE_HEIGHT, cur_h);
                end
                if ($urandom_range(0, 99) < 70)
                begin
                    thr      = ($urandom_range(0, 99) < 75) ? THR_W'($urandom_range(0, 4))
                                                            : THR_W'($urandom_range(5, 15));
                    thr_data = {7'($urandom), thr};
                    write_reg(REG_MIN_NEIGHBORS, thr_data);
                end
            end

            total     = dim_limit(cur_w, MAX_WIDTH) * (dim_limit(cur_h, MAX_HEIGHT) + 1) + 1;
            roll      = $urandom_range(0, 99);
            cut_at    = (roll < 18) ? $urandom_range(1, total - 1) : -1;
            spare_cut = roll >= 10;
            if (frame_no == 2)
                hold_go <= 1'b1;
            send_frame($urandom_range(5, 90), $urandom_range(0, 99) < 30, cut_at, spare_cut);
            frame_no++;
        end

        drain_results();
        $display("Sent %0d pixel transfers in %0d whole frames, checked %0d results, %0d writes.",
                 items_sent, frames_done, results_seen, cfg_writes);
        $display("Sizes ran from 3x3 up to 14 wide and 10 tall, thresholds from 0 to 15.");
        if (failures == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches, %0d results still awaited.", failures, pending);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
